### hdl/ipv4fhg_pkg.sv
package ipv4fhg_pkg;

  // Header constants.
  localparam logic [13:0] MTU_MIN   = 14'd1100;
  localparam logic [13:0] MTU_MAX   = 14'd9000;
  localparam logic [13:0] MTU_RESET = 14'd1500;
  localparam logic [13:0] HDR_BYTES = 14'd20;
  localparam logic [15:0] VER_IHL_WORD = 16'h4500;
  localparam logic [15:0] TTL_WORD     = 16'hFF00;
  localparam logic [15:0] FLAG_DF      = 16'h4000;
  localparam logic [15:0] FLAG_MF      = 16'h2000;

  // One datagram request.
  typedef struct packed {
    logic [15:0] payload_length;
    logic [7:0]  type_of_service;
    logic [7:0]  protocol_number;
    logic [31:0] source_address;
    logic [31:0] dest_address;
  } in_item_t;

  // One header result.
  typedef struct packed {
    logic [13:0] total_length;
    logic [15:0] ident;
    logic [12:0] fragment_offset;
    logic        more_fragments;
    logic        dont_fragment;
    logic [15:0] header_checksum;
    logic [15:0] payload_start;
    logic [13:0] payload_bytes;
    logic        last;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic setup;
    logic emit;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic slot_free;
    logic fin;
  } dp_status_t;

  // Controller states, one-hot.
  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SETUP = 3'b010,
    ST_EMIT  = 3'b100
  } state_t;

endpackage

### hdl/ipv4_fragment_header_gen.sv
// Channel  Ports                         Transfer
// input    in_valid/in_ready/in_data     one datagram request per transaction
// output   out_valid/out_ready/out_data  one header (packet or fragment) per transaction
// config   cfg_wr_en/cfg_wr_data         link MTU write, no wait
//
// A datagram produces N headers, N being 1 to 61. The request is captured,
// then the fixed checksum words and fragment size are formed, then the emit
// sequencer gives one header per cycle.
// A stalled output holds the sequencer; a new request is taken as soon as
// the last header sits in the output register. Reset is synchronous, active
// low, and sets the MTU to 1500 and the identification counter to zero.
module ipv4_fragment_header_gen (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  ipv4fhg_pkg::in_item_t  in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output ipv4fhg_pkg::out_item_t out_data,
  input  logic                   cfg_wr_en,
  input  logic [13:0]            cfg_wr_data
);

  ipv4fhg_pkg::dp_cmd_t    cmd;
  ipv4fhg_pkg::dp_status_t status;

  // Sequencer.
  ipv4fhg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Header datapath and output register.
  ipv4fhg_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule

### hdl/ipv4fhg_ctrl.sv
module ipv4fhg_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  ipv4fhg_pkg::dp_status_t status,
  output ipv4fhg_pkg::dp_cmd_t    cmd
);

  ipv4fhg_pkg::state_t state_r, state_nxt;

  // Command decode and next state.
  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    cmd.load_in = 1'b0;
    cmd.setup   = 1'b0;
    cmd.emit    = 1'b0;
    unique case (state_r)
      ipv4fhg_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
        if (in_valid) begin
          state_nxt = ipv4fhg_pkg::ST_SETUP;
        end
      end
      ipv4fhg_pkg::ST_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = ipv4fhg_pkg::ST_EMIT;
      end
      ipv4fhg_pkg::ST_EMIT: begin
        cmd.emit = status.slot_free;
        if (status.slot_free && status.fin) begin
          state_nxt = ipv4fhg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ipv4fhg_pkg::ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ipv4fhg_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### hdl/ipv4fhg_dp.sv
module ipv4fhg_dp (
  input  logic                    clk,
  input  logic                    rst_n,
  input  ipv4fhg_pkg::in_item_t   in_data,
  input  logic                    cfg_wr_en,
  input  logic [13:0]             cfg_wr_data,
  input  ipv4fhg_pkg::dp_cmd_t    cmd,
  output ipv4fhg_pkg::dp_status_t status,
  output logic                    out_valid,
  input  logic                    out_ready,
  output ipv4fhg_pkg::out_item_t  out_data
);

  logic [13:0] mtu_r;
  logic [15:0] ident_ctr_r;
  logic [15:0] id_r;
  logic [15:0] len_r;
  logic [7:0]  tos_r;
  logic [7:0]  proto_r;
  logic [31:0] src_r;
  logic [31:0] dst_r;
  logic [18:0] base_r;
  logic [13:0] chunk_r;
  logic        single_r;
  logic [15:0] pos_r;
  logic [15:0] rem_r;
  logic        out_valid_r;
  ipv4fhg_pkg::out_item_t out_data_r;

  logic [13:0] mtu_c;
  logic [13:0] mtu_less_hdr;
  logic [18:0] base_nxt;
  logic        fin;
  logic [13:0] bytes;
  logic [13:0] tot;
  logic [12:0] off;
  logic [15:0] flagoff;
  logic [20:0] sum;
  logic [16:0] fold1;
  logic [15:0] fold2;
  ipv4fhg_pkg::out_item_t res;

  // Clamp the link MTU into the supported range.
  always_comb begin
    if (mtu_r < ipv4fhg_pkg::MTU_MIN) begin
      mtu_c = ipv4fhg_pkg::MTU_MIN;
    end else if (mtu_r > ipv4fhg_pkg::MTU_MAX) begin
      mtu_c = ipv4fhg_pkg::MTU_MAX;
    end else begin
      mtu_c = mtu_r;
    end
  end
  assign mtu_less_hdr = mtu_c - ipv4fhg_pkg::HDR_BYTES;

  // Checksum words that stay the same for every fragment of the datagram.
  assign base_nxt = 19'(ipv4fhg_pkg::VER_IHL_WORD | {8'h00, tos_r})
                  + 19'(ipv4fhg_pkg::TTL_WORD | {8'h00, proto_r})
                  + 19'(src_r[31:16]) + 19'(src_r[15:0])
                  + 19'(dst_r[31:16]) + 19'(dst_r[15:0])
                  + 19'(id_r);

  // Current fragment.
  assign fin   = single_r || (rem_r <= {2'b00, chunk_r});
  assign bytes = fin ? rem_r[13:0] : chunk_r;
  assign tot   = bytes + ipv4fhg_pkg::HDR_BYTES;
  assign off   = pos_r[15:3];

  always_comb begin
    if (single_r) begin
      flagoff = ipv4fhg_pkg::FLAG_DF;
    end else if (fin) begin
      flagoff = {3'b000, off};
    end else begin
      flagoff = ipv4fhg_pkg::FLAG_MF | {3'b000, off};
    end
  end

  // Ones'-complement sum with two end-around carry folds.
  assign sum   = {2'b00, base_r} + {7'd0, tot} + {5'd0, flagoff};
  assign fold1 = {1'b0, sum[15:0]} + {12'd0, sum[20:16]};
  assign fold2 = fold1[15:0] + {15'd0, fold1[16]};

  always_comb begin
    res.total_length    = tot;
    res.ident           = id_r;
    res.fragment_offset = single_r ? 13'd0 : off;
    res.more_fragments  = !fin;
    res.dont_fragment   = single_r;
    res.header_checksum = ~fold2;
    res.payload_start   = pos_r;
    res.payload_bytes   = bytes;
    res.last            = fin;
  end

  // Control registers: MTU, identification counter, output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mtu_r       <= ipv4fhg_pkg::MTU_RESET;
      ident_ctr_r <= 16'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        mtu_r <= cfg_wr_data;
      end
      if (cmd.load_in) begin
        ident_ctr_r <= ident_ctr_r + 16'd1;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      len_r   <= in_data.payload_length;
      tos_r   <= in_data.type_of_service;
      proto_r <= in_data.protocol_number;
      src_r   <= in_data.source_address;
      dst_r   <= in_data.dest_address;
      id_r    <= ident_ctr_r;
    end
    if (cmd.setup) begin
      base_r   <= base_nxt;
      chunk_r  <= {mtu_less_hdr[13:3], 3'b000};
      single_r <= ({1'b0, len_r} + 17'd20) <= {3'b000, mtu_c};
      pos_r    <= 16'd0;
      rem_r    <= len_r;
    end
    if (cmd.emit) begin
      out_data_r <= res;
      pos_r      <= pos_r + {2'b00, chunk_r};
      rem_r      <= rem_r - {2'b00, chunk_r};
    end
  end

  assign status.slot_free = !out_valid_r || out_ready;
  assign status.fin       = fin;
  assign out_valid        = out_valid_r;
  assign out_data         = out_data_r;

endmodule

### sim/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_HEADERS     = 61;
  localparam int QUIET_CYCLES    = 4;
  localparam int TAIL_CYCLES     = 20;
  localparam int RAND_PHASES     = 8;
  localparam int ITEMS_PER_PHASE = 31;
  localparam int CYCLE_LIMIT     = 1000000;

  // Receiver behavior, redrawn at random by the stall process.
  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_COIN,
    RDY_SPARSE,
    RDY_TOGGLE
  } ready_mode_t;

  // One row of the directed table: an optional MTU write before the request,
  // and, where it is obvious, the single header the request must produce.
  typedef struct packed {
    logic                   set_mtu;
    logic [13:0]            mtu;
    ipv4fhg_pkg::in_item_t  req;
    logic                   typed;
    ipv4fhg_pkg::out_item_t hdr;
  } dir_row_t;

  localparam int DIR_ROWS = 19;
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    // Reset MTU, empty payload, all fields zero.
    '{1'b0, 14'd0, '{16'd0, 8'h00, 8'h00, 32'h0000_0000, 32'h0000_0000}, 1'b1,
      '{14'd20, 16'd0, 13'd0, 1'b0, 1'b1, 16'h7BEA, 16'd0, 14'd0, 1'b1}},
    // Empty payload, all header fields at their maximum.
    '{1'b0, 14'd0, '{16'd0, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1,
      '{14'd20, 16'd1, 13'd0, 1'b0, 1'b1, 16'h79EB, 16'd0, 14'd0, 1'b1}},
    // Payload that exactly fills a 1500-byte datagram.
    '{1'b0, 14'd0, '{16'd1480, 8'h00, 8'h00, 32'h0000_0000, 32'h0000_0000}, 1'b1,
      '{14'd1500, 16'd2, 13'd0, 1'b0, 1'b1, 16'h7620, 16'd0, 14'd1480, 1'b1}},
    '{1'b0, 14'd0, '{16'd1481, 8'h10, 8'h11, 32'hC0A8_0001, 32'hC0A8_00FE}, 1'b0, '0},
    '{1'b0, 14'd0, '{16'd2960, 8'h00, 8'h06, 32'h0A00_0001, 32'h0A00_0002}, 1'b0, '0},
    '{1'b0, 14'd0, '{16'd65535, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b0, '0},
    // Smallest supported MTU.
    '{1'b1, 14'd1100, '{16'd1080, 8'hA5, 8'h5A, 32'h1234_5678, 32'h9ABC_DEF0}, 1'b0, '0},
    '{1'b0, 14'd0, '{16'd1081, 8'h5A, 8'hA5, 32'h8765_4321, 32'h0FED_CBA9}, 1'b0, '0},
    '{1'b0, 14'd0, '{16'd65535, 8'h00, 8'h11, 32'hAC10_0001, 32'hE000_0001}, 1'b0, '0},
    '{1'b0, 14'd0, '{16'd65515, 8'h80, 8'h01, 32'h7FFF_FFFF, 32'h8000_0000}, 1'b0, '0},
    // Largest supported MTU.
    '{1'b1, 14'd9000, '{16'd8980, 8'h01, 8'h80, 32'h0000_FFFF, 32'hFFFF_0000}, 1'b0, '0},
    '{1'b0, 14'd0, '{16'd8981, 8'h3C, 8'hC3, 32'h5555_5555, 32'hAAAA_AAAA}, 1'b0, '0},
    '{1'b0, 14'd0, '{16'd65535, 8'hFF, 8'h00, 32'hFFFF_FFFF, 32'h0000_0000}, 1'b0, '0},
    // MTU settings outside the supported range are clamped.
    '{1'b1, 14'd1099, '{16'd65535, 8'h0F, 8'hF0, 32'hDEAD_BEEF, 32'hCAFE_F00D}, 1'b0, '0},
    '{1'b1, 14'd0, '{16'd2000, 8'hC0, 8'h2F, 32'h0102_0304, 32'h0506_0708}, 1'b0, '0},
    '{1'b1, 14'd16383, '{16'd8981, 8'h22, 8'h33, 32'h4444_4444, 32'h6666_6666}, 1'b0, '0},
    '{1'b1, 14'd9001, '{16'd8980, 8'hEE, 8'h99, 32'hF0F0_F0F0, 32'h0F0F_0F0F}, 1'b0, '0},
    // Chunk size rounds down to a multiple of 8 bytes.
    '{1'b1, 14'd1501, '{16'd2961, 8'h07, 8'h70, 32'h1111_2222, 32'h3333_4444}, 1'b0, '0},
    '{1'b1, 14'd1500, '{16'd1, 8'h00, 8'hFE, 32'h8000_0000, 32'h0000_0001}, 1'b0, '0}
  };

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  ipv4fhg_pkg::in_item_t  in_data = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  ipv4fhg_pkg::out_item_t out_data;
  logic                   cfg_wr_en = 1'b0;
  logic [13:0]            cfg_wr_data = '0;

  // Side information that travels with each request transaction.
  logic                   req_typed = 1'b0;
  ipv4fhg_pkg::out_item_t req_typed_hdr = '0;

  // Copy of the block's state and the headers still to come.
  logic [13:0]            mtu_setting;
  logic [15:0]            next_ident;
  ipv4fhg_pkg::out_item_t pending_headers[$];
  ipv4fhg_pkg::out_item_t oldest_header;

  int          error_count = 0;
  int          cycle_count = 0;
  int          burst_left = 0;
  ready_mode_t ready_mode = RDY_ALWAYS;

  ipv4_fragment_header_gen u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #6 clk = ~clk;

  // Ones'-complement sum of the ten header words, checksum word taken as zero.
  function automatic logic [15:0] header_sum(ipv4fhg_pkg::in_item_t r,
                                             logic [13:0] tot,
                                             logic [15:0] id,
                                             logic [15:0] flags_off);
    logic [19:0] acc;
    acc = 20'(ipv4fhg_pkg::VER_IHL_WORD | {8'd0, r.type_of_service})
        + 20'(tot) + 20'(id) + 20'(flags_off)
        + 20'(ipv4fhg_pkg::TTL_WORD | {8'd0, r.protocol_number})
        + 20'(r.source_address[31:16]) + 20'(r.source_address[15:0])
        + 20'(r.dest_address[31:16]) + 20'(r.dest_address[15:0]);
    acc = 20'(acc[15:0]) + 20'(acc[19:16]);
    acc = 20'(acc[15:0]) + 20'(acc[19:16]);
    return ~acc[15:0];
  endfunction

  // Work out every header that one datagram request produces and queue them.
  function automatic void form_headers(ipv4fhg_pkg::in_item_t r);
    logic [13:0]            mtu;
    logic [13:0]            chunk;
    logic [16:0]            pos;
    logic [16:0]            left;
    logic [15:0]            id;
    ipv4fhg_pkg::out_item_t h;
    int                     n;
    mtu = (mtu_setting < ipv4fhg_pkg::MTU_MIN) ? ipv4fhg_pkg::MTU_MIN :
          (mtu_setting > ipv4fhg_pkg::MTU_MAX) ? ipv4fhg_pkg::MTU_MAX : mtu_setting;
    id = next_ident;
    next_ident = next_ident + 16'd1;
    h = '0;
    h.ident = id;
    if ({1'b0, r.payload_length} + 17'd20 <= {3'd0, mtu}) begin
      // Fits the link: one header with DF set.
      h.total_length    = r.payload_length[13:0] + ipv4fhg_pkg::HDR_BYTES;
      h.dont_fragment   = 1'b1;
      h.payload_bytes   = r.payload_length[13:0];
      h.last            = 1'b1;
      h.header_checksum = header_sum(r, h.total_length, id, ipv4fhg_pkg::FLAG_DF);
      pending_headers.push_back(h);
      return;
    end
    chunk = (mtu - ipv4fhg_pkg::HDR_BYTES) & ~14'd7;
    n = 0;
    for (pos = '0; pos < {1'b0, r.payload_length} && n < MAX_HEADERS;
         pos = pos + 17'(chunk)) begin
      left = {1'b0, r.payload_length} - pos;
      h.last            = (left <= {3'd0, chunk});
      h.payload_bytes   = h.last ? left[13:0] : chunk;
      h.total_length    = ipv4fhg_pkg::HDR_BYTES + h.payload_bytes;
      h.fragment_offset = pos[15:3];
      h.more_fragments  = ~h.last;
      h.dont_fragment   = 1'b0;
      h.payload_start   = pos[15:0];
      h.header_checksum = header_sum(r, h.total_length, id,
                                     {2'b00, h.more_fragments, h.fragment_offset});
      pending_headers.push_back(h);
      n++;
    end
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      error_count++;
    end
  endfunction

  // Scoreboard: compare result transactions, track the MTU and predict on
  // every accepted request.
  always @(posedge clk) begin
    if (!rst_n) begin
      mtu_setting = ipv4fhg_pkg::MTU_RESET;
      next_ident  = '0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_headers.size() == 0) begin
          $error("header transaction with nothing expected: %p", out_data);
          error_count++;
        end else begin
          oldest_header = pending_headers.pop_front();
          check_field("total_length", 16'(oldest_header.total_length),
                      16'(out_data.total_length));
          check_field("ident", oldest_header.ident, out_data.ident);
          check_field("fragment_offset", 16'(oldest_header.fragment_offset),
                      16'(out_data.fragment_offset));
          check_field("more_fragments", 16'(oldest_header.more_fragments),
                      16'(out_data.more_fragments));
          check_field("dont_fragment", 16'(oldest_header.dont_fragment),
                      16'(out_data.dont_fragment));
          check_field("header_checksum", oldest_header.header_checksum,
                      out_data.header_checksum);
          check_field("payload_start", oldest_header.payload_start,
                      out_data.payload_start);
          check_field("payload_bytes", 16'(oldest_header.payload_bytes),
                      16'(out_data.payload_bytes));
          check_field("last", 16'(oldest_header.last), 16'(out_data.last));
        end
      end
      if (cfg_wr_en) begin
        mtu_setting = cfg_wr_data;
      end
      if (in_valid && in_ready) begin
        form_headers(in_data);
        if (req_typed) begin
          // A table row with a written-out header replaces the predicted one.
          void'(pending_headers.pop_back());
          pending_headers.push_back(req_typed_hdr);
        end
      end
    end
  end

  // Receiver stalls on a pattern that is redrawn at random as the run goes on.
  always @(posedge clk) begin
    if (cycle_count % 128 == 0) begin
      ready_mode <= ready_mode_t'($urandom_range(0, 3));
    end
    case (ready_mode)
      RDY_ALWAYS: out_ready <= 1'b1;
      RDY_COIN:   out_ready <= ($urandom_range(0, 1) != 0);
      RDY_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
      default:    out_ready <= ~out_ready;
    endcase
  end

  // Run time guard.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Present one request and hold it until the transaction completes. The
  // sender runs in bursts with random gaps between them.
  task automatic send_request(input ipv4fhg_pkg::in_item_t req, input logic typed,
                              input ipv4fhg_pkg::out_item_t hdr);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid      <= 1'b1;
    in_data       <= req;
    req_typed     <= typed;
    req_typed_hdr <= hdr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Stop sending and wait until every expected header has arrived.
  task automatic wait_quiet();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_headers.size() != 0) @(negedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_mtu(input logic [13:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Random request whose length leans toward short payloads, with some near
  // the fragmentation boundary and a few of the largest sizes.
  function automatic ipv4fhg_pkg::in_item_t random_request(int limit);
    ipv4fhg_pkg::in_item_t r;
    int                    len;
    r.type_of_service = 8'($urandom);
    r.protocol_number = 8'($urandom);
    r.source_address  = $urandom;
    r.dest_address    = $urandom;
    case ($urandom_range(0, 15))
      0:                   len = 0;
      1, 2, 3, 4, 5, 6, 7: len = $urandom_range(1, 1500);
      8, 9, 10:            len = limit - 23 + int'($urandom_range(0, 6));
      11, 12, 13:          len = $urandom_range(1, 3 * limit);
      14:                  len = $urandom_range(0, 65535);
      default:             len = ($urandom_range(0, 1) != 0) ? 65535 : 65515;
    endcase
    r.payload_length = len[15:0];
    return r;
  endfunction

  // Stimulus: reset, directed table, then random phases at several MTUs.
  initial begin
    logic [13:0] mtu;
    int          limit;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIR_TABLE[i]) begin
      if (DIR_TABLE[i].set_mtu) begin
        wait_quiet();
        write_mtu(DIR_TABLE[i].mtu);
      end
      send_request(DIR_TABLE[i].req, DIR_TABLE[i].typed, DIR_TABLE[i].hdr);
    end

    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0:       mtu = ipv4fhg_pkg::MTU_MIN;
        1:       mtu = ipv4fhg_pkg::MTU_MAX;
        default: begin
          case ($urandom_range(0, 9))
            0:       mtu = 14'($urandom_range(0, 1099));
            1:       mtu = 14'($urandom_range(9001, 16383));
            default: mtu = 14'($urandom_range(1100, 9000));
          endcase
        end
      endcase
      limit = int'((mtu < ipv4fhg_pkg::MTU_MIN) ? ipv4fhg_pkg::MTU_MIN :
                   (mtu > ipv4fhg_pkg::MTU_MAX) ? ipv4fhg_pkg::MTU_MAX : mtu);
      wait_quiet();
      write_mtu(mtu);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        // Now and then let the block drain completely before the next request.
        if ($urandom_range(0, 29) == 0) begin
          wait_quiet();
        end
        send_request(random_request(limit), 1'b0, '0);
      end
    end

    wait_quiet();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_headers.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
